// ----- rtl/core/cpi_pkg.sv -----
// cpi_pkg: shared types, widths and helpers for the circle pair intersection unit
// used by circle_pair_intersection_unit; its pipelined arithmetic units do not use it
package cpi_pkg;

    // default coordinate width and fixed field widths
    localparam int COORD_BITS_DEF = 16;
    localparam int ID_W           = 16;
    localparam int PT_W           = 19;
    localparam int STATUS_W       = 2;

    // saturation limits of a point coordinate
    localparam int PT_MIN = -262144;
    localparam int PT_MAX = 262143;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_SAME_ID   = 2'd1,
        ST_TOO_FAR   = 2'd2,
        ST_CONTAINED = 2'd3
    } status_t;

    // clamp a wide signed value into the point range
    function automatic logic signed [PT_W-1:0] sat_point(input logic signed [31:0] v);
        logic signed [31:0] c;
        c = v;
        if (c < PT_MIN)
        begin
            c = PT_MIN;
        end
        if (c > PT_MAX)
        begin
            c = PT_MAX;
        end
        return PT_W'(c);
    endfunction

endpackage

// ----- rtl/core/circle_pair_intersection_unit.sv -----
// circle_pair_intersection_unit: intersection points of two circles, exact integers
// depends on cpi_pkg, cpi_sqrt_pipe and cpi_div_pipe
//
//   channel  handshake             payload
//   -------  --------------------  -----------------------------------------------
//   in       in_valid / in_ready   first_x/y/radius/id, second_x/y/radius/id
//   out      out_valid / out_ready status, point_one_x/y, point_two_x/y
//
// the pipe runs through two root units and three dividers of one bit per stage
// plus nine arithmetic stages and the output register
// one word enters per cycle while the output word is not held; every stage advances together
// in_ready is low only while a finished word waits at the output and out_ready is low
// reset clears the valid bits only; there is no clearing pass
module circle_pair_intersection_unit #(
    parameter int COORD_BITS = cpi_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [COORD_BITS-1:0]       first_x,
    input  logic signed [COORD_BITS-1:0]       first_y,
    input  logic        [COORD_BITS-1:0]       first_radius,
    input  logic        [cpi_pkg::ID_W-1:0]    first_id,
    input  logic signed [COORD_BITS-1:0]       second_x,
    input  logic signed [COORD_BITS-1:0]       second_y,
    input  logic        [COORD_BITS-1:0]       second_radius,
    input  logic        [cpi_pkg::ID_W-1:0]    second_id,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic        [cpi_pkg::STATUS_W-1:0] status,
    output logic signed [cpi_pkg::PT_W-1:0]    point_one_x,
    output logic signed [cpi_pkg::PT_W-1:0]    point_one_y,
    output logic signed [cpi_pkg::PT_W-1:0]    point_two_x,
    output logic signed [cpi_pkg::PT_W-1:0]    point_two_y
);

    import cpi_pkg::*;

    localparam int C = COORD_BITS;

    // data carried alongside the arithmetic units
    typedef struct packed {
        logic signed [C:0]     dx;
        logic signed [C:0]     dy;
        logic signed [C-1:0]   x0;
        logic signed [C-1:0]   y0;
        logic        [C-1:0]   r0;
        logic        [C-1:0]   r1;
        logic                  sid;
        logic signed [2*C:0]   rr;
        logic        [2*C-1:0] r0sq;
        logic        [2*C:0]   d2;
    } dist_side_t;

    typedef struct packed {
        status_t               st;
        logic                  neg;
        logic signed [C:0]     dx;
        logic signed [C:0]     dy;
        logic signed [C-1:0]   x0;
        logic signed [C-1:0]   y0;
        logic        [2*C-1:0] r0sq;
        logic        [C:0]     d;
    } chord_side_t;

    typedef struct packed {
        status_t           st;
        logic signed [C:0] dx;
        logic signed [C:0] dy;
    } half_side_t;

    typedef struct packed {
        logic signed [C-1:0] x0;
        logic signed [C-1:0] y0;
        logic                sx;
        logic                sy;
        logic        [C:0]   d;
    } mid_side_t;

    typedef struct packed {
        status_t             st;
        logic signed [C+2:0] mx;
        logic signed [C+2:0] my;
        logic                sdy;
        logic                sdx;
    } off_side_t;

    logic adv;

    // stage 1: deltas and id check
    logic                s1_vld_reg;
    logic signed [C:0]   s1_dx_reg, s1_dy_reg;
    logic signed [C-1:0] s1_x0_reg, s1_y0_reg;
    logic        [C-1:0] s1_r0_reg, s1_r1_reg;
    logic                s1_sid_reg;

    // stage 2: squares
    logic signed [2*C+1:0] dxsq_full, dysq_full;
    logic                  s2_vld_reg;
    logic        [2*C-1:0] s2_dxsq_reg, s2_dysq_reg, s2_r0sq_reg, s2_r1sq_reg;
    logic signed [C:0]     s2_dx_reg, s2_dy_reg;
    logic signed [C-1:0]   s2_x0_reg, s2_y0_reg;
    logic        [C-1:0]   s2_r0_reg, s2_r1_reg;
    logic                  s2_sid_reg;

    // stage 3: squared distance and radius difference
    logic                  s3_vld_reg;
    dist_side_t            s3_side_reg;

    // distance root
    logic                  sq1_vld;
    logic        [C:0]     sq1_root;
    dist_side_t            sq1_side;

    // stage 4: case checks and chord numerator
    logic        [C:0]     sum_r;
    logic        [C-1:0]   diff_r;
    logic signed [2*C+2:0] numa;
    status_t               st_c;
    logic                  s4_vld_reg;
    chord_side_t           s4_side_reg;
    logic        [2*C+1:0] s4_maga_reg;
    logic        [C+1:0]   s4_dena_reg;

    // chord distance divider
    logic                  da_vld;
    logic        [C:0]     da_quo;
    chord_side_t           da_side;

    // stage 5: signed chord distance
    logic signed [C+1:0]   a_c;
    logic                  s5_vld_reg;
    logic signed [C+1:0]   s5_a_reg;
    chord_side_t           s5_side_reg;

    // stage 6: products with a
    logic signed [2*C+2:0] pxa_full, pya_full;
    logic signed [2*C+3:0] asq_full;
    logic                  s6_vld_reg;
    logic signed [2*C+2:0] s6_pxa_reg, s6_pya_reg;
    logic        [2*C+1:0] s6_asq_reg;
    chord_side_t           s6_side_reg;

    // stage 7: half-chord radicand and midpoint magnitudes
    logic signed [2*C+2:0] radf;
    logic        [2*C+2:0] pxa_mag, pya_mag;
    logic                  s7_vld_reg;
    logic        [2*C-1:0] s7_rad_reg;
    logic        [2*C+1:0] s7_mxm_reg, s7_mym_reg;
    half_side_t            s7_half_reg;
    mid_side_t             s7_mid_reg;

    // half-chord root and midpoint divider
    logic                  sq2_vld;
    logic        [C:0]     sq2_root;
    half_side_t            sq2_side;
    logic                  db_vld;
    logic [1:0][C:0]       db_quo;
    mid_side_t             db_side;

    // stage 8: midpoint and offset products
    logic signed [C+2:0]   qxs, qys;
    logic signed [C+2:0]   mx_c, my_c;
    logic signed [C:0]     h_s;
    logic signed [2*C+1:0] phx_c, phy_c;
    logic                  s8_vld_reg;
    logic signed [C+2:0]   s8_mx_reg, s8_my_reg;
    logic signed [2*C+1:0] s8_phx_reg, s8_phy_reg;
    status_t               s8_st_reg;
    logic        [C:0]     s8_d_reg;

    // stage 9: offset magnitudes
    logic        [2*C+1:0] phx_mag, phy_mag;
    logic                  s9_vld_reg;
    logic        [2*C-1:0] s9_phxm_reg, s9_phym_reg;
    off_side_t             s9_side_reg;
    logic        [C:0]     s9_d_reg;

    // offset divider
    logic                  dc_vld;
    logic [1:0][C-1:0]     dc_quo;
    off_side_t             dc_side;

    // output register
    logic signed [C+3:0]   rx_c, ry_c;
    logic signed [C+3:0]   p1x_c, p1y_c, p2x_c, p2y_c;
    logic                  out_valid_reg;
    status_t               status_reg;
    logic signed [PT_W-1:0] p1x_reg, p1y_reg, p2x_reg, p2y_reg;

    // whole pipe advances unless the output word is held
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dx_reg  <= (C+1)'(second_x) - (C+1)'(first_x);
            s1_dy_reg  <= (C+1)'(second_y) - (C+1)'(first_y);
            s1_x0_reg  <= first_x;
            s1_y0_reg  <= first_y;
            s1_r0_reg  <= first_radius;
            s1_r1_reg  <= second_radius;
            s1_sid_reg <= (first_id == second_id);
        end
    end

    // stage 2
    assign dxsq_full = s1_dx_reg * s1_dx_reg;
    assign dysq_full = s1_dy_reg * s1_dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_dxsq_reg <= dxsq_full[2*C-1:0];
            s2_dysq_reg <= dysq_full[2*C-1:0];
            s2_r0sq_reg <= s1_r0_reg * s1_r0_reg;
            s2_r1sq_reg <= s1_r1_reg * s1_r1_reg;
            s2_dx_reg   <= s1_dx_reg;
            s2_dy_reg   <= s1_dy_reg;
            s2_x0_reg   <= s1_x0_reg;
            s2_y0_reg   <= s1_y0_reg;
            s2_r0_reg   <= s1_r0_reg;
            s2_r1_reg   <= s1_r1_reg;
            s2_sid_reg  <= s1_sid_reg;
        end
    end

    // stage 3
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_side_reg.dx   <= s2_dx_reg;
            s3_side_reg.dy   <= s2_dy_reg;
            s3_side_reg.x0   <= s2_x0_reg;
            s3_side_reg.y0   <= s2_y0_reg;
            s3_side_reg.r0   <= s2_r0_reg;
            s3_side_reg.r1   <= s2_r1_reg;
            s3_side_reg.sid  <= s2_sid_reg;
            s3_side_reg.rr   <= $signed({1'b0, s2_r0sq_reg}) - $signed({1'b0, s2_r1sq_reg});
            s3_side_reg.r0sq <= s2_r0sq_reg;
            s3_side_reg.d2   <= {1'b0, s2_dxsq_reg} + {1'b0, s2_dysq_reg};
        end
    end

    // distance between centres
    cpi_sqrt_pipe #(
        .K      (C + 1),
        .SIDE_W ($bits(dist_side_t))
    ) u_sqrt_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s3_vld_reg),
        .val      ({1'b0, s3_side_reg.d2}),
        .side_in  (s3_side_reg),
        .out_vld  (sq1_vld),
        .root     (sq1_root),
        .side_out (sq1_side)
    );

    // stage 4: classify and form r0^2 - r1^2 + d^2
    always_comb
    begin
        sum_r  = {1'b0, sq1_side.r0} + {1'b0, sq1_side.r1};
        diff_r = (sq1_side.r0 >= sq1_side.r1) ? (sq1_side.r0 - sq1_side.r1)
                                              : (sq1_side.r1 - sq1_side.r0);
        if (sq1_side.sid)
        begin
            st_c = ST_SAME_ID;
        end
        else if (sq1_root > sum_r)
        begin
            st_c = ST_TOO_FAR;
        end
        else if ((sq1_root < {1'b0, diff_r}) || (sq1_root == '0))
        begin
            st_c = ST_CONTAINED;
        end
        else
        begin
            st_c = ST_OK;
        end
        numa = {{2{sq1_side.rr[2*C]}}, sq1_side.rr} + {2'b00, sq1_side.d2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_vld_reg <= sq1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_side_reg.st   <= st_c;
            s4_side_reg.neg  <= numa[2*C+2];
            s4_side_reg.dx   <= sq1_side.dx;
            s4_side_reg.dy   <= sq1_side.dy;
            s4_side_reg.x0   <= sq1_side.x0;
            s4_side_reg.y0   <= sq1_side.y0;
            s4_side_reg.r0sq <= sq1_side.r0sq;
            s4_side_reg.d    <= sq1_root;
            s4_maga_reg      <= numa[2*C+2] ? (2*C+2)'(-numa) : numa[2*C+1:0];
            s4_dena_reg      <= {sq1_root, 1'b0};
        end
    end

    // distance from first centre to chord midpoint
    cpi_div_pipe #(
        .N      (2*C + 2),
        .D      (C + 2),
        .Q      (C + 1),
        .LANES  (1),
        .SIDE_W ($bits(chord_side_t))
    ) u_div_chord (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s4_vld_reg),
        .num      (s4_maga_reg),
        .den      (s4_dena_reg),
        .side_in  (s4_side_reg),
        .out_vld  (da_vld),
        .quo      (da_quo),
        .side_out (da_side)
    );

    // stage 5
    assign a_c = da_side.neg ? -$signed({1'b0, da_quo}) : $signed({1'b0, da_quo});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s5_vld_reg <= da_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_a_reg    <= a_c;
            s5_side_reg <= da_side;
        end
    end

    // stage 6
    assign pxa_full = s5_side_reg.dx * s5_a_reg;
    assign pya_full = s5_side_reg.dy * s5_a_reg;
    assign asq_full = s5_a_reg * s5_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_pxa_reg  <= pxa_full;
            s6_pya_reg  <= pya_full;
            s6_asq_reg  <= asq_full[2*C+1:0];
            s6_side_reg <= s5_side_reg;
        end
    end

    // stage 7: clamp negative radicand to zero
    always_comb
    begin
        radf    = $signed({3'b000, s6_side_reg.r0sq}) - $signed({1'b0, s6_asq_reg});
        pxa_mag = s6_pxa_reg[2*C+2] ? (2*C+3)'(-s6_pxa_reg) : s6_pxa_reg;
        pya_mag = s6_pya_reg[2*C+2] ? (2*C+3)'(-s6_pya_reg) : s6_pya_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s7_vld_reg <= s6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_rad_reg     <= radf[2*C+2] ? '0 : radf[2*C-1:0];
            s7_mxm_reg     <= pxa_mag[2*C+1:0];
            s7_mym_reg     <= pya_mag[2*C+1:0];
            s7_half_reg.st <= s6_side_reg.st;
            s7_half_reg.dx <= s6_side_reg.dx;
            s7_half_reg.dy <= s6_side_reg.dy;
            s7_mid_reg.x0  <= s6_side_reg.x0;
            s7_mid_reg.y0  <= s6_side_reg.y0;
            s7_mid_reg.sx  <= s6_pxa_reg[2*C+2];
            s7_mid_reg.sy  <= s6_pya_reg[2*C+2];
            s7_mid_reg.d   <= s6_side_reg.d;
        end
    end

    // half-chord length
    cpi_sqrt_pipe #(
        .K      (C + 1),
        .SIDE_W ($bits(half_side_t))
    ) u_sqrt_half (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s7_vld_reg),
        .val      ({2'b00, s7_rad_reg}),
        .side_in  (s7_half_reg),
        .out_vld  (sq2_vld),
        .root     (sq2_root),
        .side_out (sq2_side)
    );

    // midpoint offsets along the centre line, same latency as the root
    cpi_div_pipe #(
        .N      (2*C + 2),
        .D      (C + 1),
        .Q      (C + 1),
        .LANES  (2),
        .SIDE_W ($bits(mid_side_t))
    ) u_div_mid (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s7_vld_reg),
        .num      ({s7_mym_reg, s7_mxm_reg}),
        .den      (s7_mid_reg.d),
        .side_in  (s7_mid_reg),
        .out_vld  (db_vld),
        .quo      (db_quo),
        .side_out (db_side)
    );

    // stage 8: midpoint and perpendicular products
    always_comb
    begin
        qxs   = db_side.sx ? -$signed({2'b00, db_quo[0]}) : $signed({2'b00, db_quo[0]});
        qys   = db_side.sy ? -$signed({2'b00, db_quo[1]}) : $signed({2'b00, db_quo[1]});
        mx_c  = (C+3)'(db_side.x0) + qxs;
        my_c  = (C+3)'(db_side.y0) + qys;
        h_s   = $signed({1'b0, sq2_root[C-1:0]});
        phx_c = sq2_side.dy * h_s;
        phy_c = sq2_side.dx * h_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s8_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s8_vld_reg <= sq2_vld && db_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_mx_reg  <= mx_c;
            s8_my_reg  <= my_c;
            s8_phx_reg <= phx_c;
            s8_phy_reg <= phy_c;
            s8_st_reg  <= sq2_side.st;
            s8_d_reg   <= db_side.d;
        end
    end

    // stage 9
    always_comb
    begin
        phx_mag = s8_phx_reg[2*C+1] ? (2*C+2)'(-s8_phx_reg) : s8_phx_reg;
        phy_mag = s8_phy_reg[2*C+1] ? (2*C+2)'(-s8_phy_reg) : s8_phy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s9_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s9_vld_reg <= s8_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s9_phxm_reg     <= phx_mag[2*C-1:0];
            s9_phym_reg     <= phy_mag[2*C-1:0];
            s9_side_reg.st  <= s8_st_reg;
            s9_side_reg.mx  <= s8_mx_reg;
            s9_side_reg.my  <= s8_my_reg;
            s9_side_reg.sdy <= s8_phx_reg[2*C+1];
            s9_side_reg.sdx <= s8_phy_reg[2*C+1];
            s9_d_reg        <= s8_d_reg;
        end
    end

    // perpendicular offset
    cpi_div_pipe #(
        .N      (2*C),
        .D      (C + 1),
        .Q      (C),
        .LANES  (2),
        .SIDE_W ($bits(off_side_t))
    ) u_div_off (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s9_vld_reg),
        .num      ({s9_phym_reg, s9_phxm_reg}),
        .den      (s9_d_reg),
        .side_in  (s9_side_reg),
        .out_vld  (dc_vld),
        .quo      (dc_quo),
        .side_out (dc_side)
    );

    // output stage: x offset is the negated dy*h term
    always_comb
    begin
        rx_c  = dc_side.sdy ? $signed({4'b0000, dc_quo[0]}) : -$signed({4'b0000, dc_quo[0]});
        ry_c  = dc_side.sdx ? -$signed({4'b0000, dc_quo[1]}) : $signed({4'b0000, dc_quo[1]});
        p1x_c = (C+4)'(dc_side.mx) + rx_c;
        p1y_c = (C+4)'(dc_side.my) + ry_c;
        p2x_c = (C+4)'(dc_side.mx) - rx_c;
        p2y_c = (C+4)'(dc_side.my) - ry_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dc_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg <= dc_side.st;
            if (dc_side.st == ST_OK)
            begin
                p1x_reg <= sat_point(32'(p1x_c));
                p1y_reg <= sat_point(32'(p1y_c));
                p2x_reg <= sat_point(32'(p2x_c));
                p2y_reg <= sat_point(32'(p2y_c));
            end
            else
            begin
                p1x_reg <= '0;
                p1y_reg <= '0;
                p2x_reg <= '0;
                p2y_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign point_one_x = p1x_reg;
    assign point_one_y = p1y_reg;
    assign point_two_x = p2x_reg;
    assign point_two_y = p2y_reg;

    // parallel root and divider stay in lockstep
    a_half_mid_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        sq2_vld == db_vld)
        else $error("half-chord root and midpoint divider out of step");

    // a good status never reaches the chord divider with zero distance
    a_chord_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_vld_reg && (s4_side_reg.st == ST_OK)) |-> (s4_dena_reg != '0))
        else $error("chord division by zero distance");

    // failure words carry zero points
    a_fail_zero_points: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_OK)) |->
        ((p1x_reg == '0) && (p1y_reg == '0) && (p2x_reg == '0) && (p2y_reg == '0)))
        else $error("failure word with nonzero points");

endmodule

// ----- rtl/core/cpi_sqrt_pipe.sv -----
// cpi_sqrt_pipe: pipelined floor square root, one root bit per register stage
// no package dependencies; side data and a valid bit travel with each word
module cpi_sqrt_pipe #(
    parameter int K      = 17,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [2*K-1:0]    val,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_vld,
    output logic [K-1:0]      root,
    output logic [SIDE_W-1:0] side_out
);

    logic [K+1:0]      rem_reg   [1:K];
    logic [K+1:0]      rem_next  [1:K];
    logic [K-1:0]      root_reg  [1:K];
    logic [K-1:0]      root_next [1:K];
    logic [2*K-1:0]    val_reg   [1:K];
    logic [2*K-1:0]    val_next  [1:K];
    logic [SIDE_W-1:0] side_reg  [1:K];
    logic [K:1]        vld_reg;

    for (genvar s = 1; s <= K; s++)
    begin : g_stage
        logic [K+1:0]      rem_prev;
        logic [K-1:0]      root_prev;
        logic [2*K-1:0]    val_prev;
        logic [SIDE_W-1:0] side_prev;
        logic              vld_prev;
        logic [K+3:0]      cur;
        logic [K+3:0]      trial;
        logic              ge;

        // stage input: pipe input or previous stage
        if (s == 1)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign val_prev  = val;
            assign side_prev = side_in;
            assign vld_prev  = in_vld;
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[s-1];
            assign root_prev = root_reg[s-1];
            assign val_prev  = val_reg[s-1];
            assign side_prev = side_reg[s-1];
            assign vld_prev  = vld_reg[s-1];
        end

        // one restoring root step on the next two radicand bits
        always_comb
        begin
            cur          = {rem_prev, val_prev[2*K-1 -: 2]};
            trial        = (K+4)'({root_prev, 2'b01});
            ge           = (cur >= trial);
            rem_next[s]  = ge ? (K+2)'(cur - trial) : (K+2)'(cur);
            root_next[s] = {root_prev[K-2:0], ge};
            val_next[s]  = {val_prev[2*K-3:0], 2'b00};
        end

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_prev;
            end
        end

        // stage payload
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[s] <= root_next[s];
                side_reg[s] <= side_prev;
            end
        end

        // remainder and radicand only needed by later steps
        if (s < K)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next[s];
                    val_reg[s] <= val_next[s];
                end
            end
        end
    end

    assign out_vld  = vld_reg[K];
    assign root     = root_reg[K];
    assign side_out = side_reg[K];

endmodule

// ----- rtl/core/cpi_div_pipe.sv -----
// cpi_div_pipe: pipelined unsigned restoring divider, one quotient bit per stage
// lanes share one divisor; no package dependencies
module cpi_div_pipe #(
    parameter int N      = 34,
    parameter int D      = 18,
    parameter int Q      = 17,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_vld,
    input  logic [LANES-1:0][N-1:0]   num,
    input  logic [D-1:0]              den,
    input  logic [SIDE_W-1:0]         side_in,
    output logic                      out_vld,
    output logic [LANES-1:0][Q-1:0]   quo,
    output logic [SIDE_W-1:0]         side_out
);

    logic [LANES-1:0][D-1:0] rem_reg  [1:Q];
    logic [LANES-1:0][D-1:0] rem_next [1:Q];
    logic [LANES-1:0][Q-1:0] lo_reg   [1:Q];
    logic [LANES-1:0][Q-1:0] lo_next  [1:Q];
    logic [D-1:0]            den_reg  [1:Q];
    logic [SIDE_W-1:0]       side_reg [1:Q];
    logic [Q:1]              vld_reg;

    for (genvar s = 1; s <= Q; s++)
    begin : g_stage
        logic [LANES-1:0][D-1:0] rem_prev;
        logic [LANES-1:0][Q-1:0] lo_prev;
        logic [D-1:0]            den_prev;
        logic [SIDE_W-1:0]       side_prev;
        logic                    vld_prev;

        // stage input: upper dividend bits seed the remainder
        if (s == 1)
        begin : g_first
            for (genvar l = 0; l < LANES; l++)
            begin : g_seed
                assign rem_prev[l] = D'(num[l][N-1:Q]);
                assign lo_prev[l]  = num[l][Q-1:0];
            end
            assign den_prev  = den;
            assign side_prev = side_in;
            assign vld_prev  = in_vld;
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[s-1];
            assign lo_prev   = lo_reg[s-1];
            assign den_prev  = den_reg[s-1];
            assign side_prev = side_reg[s-1];
            assign vld_prev  = vld_reg[s-1];
        end

        // trial subtract per lane, quotient bit shifts in at the bottom
        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic [D:0] t;
            logic [D:0] diff;
            logic       ge;

            always_comb
            begin
                t              = {rem_prev[l], lo_prev[l][Q-1]};
                diff           = t - {1'b0, den_prev};
                ge             = !diff[D];
                rem_next[s][l] = ge ? diff[D-1:0] : t[D-1:0];
                lo_next[s][l]  = {lo_prev[l][Q-2:0], ge};
            end
        end

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_prev;
            end
        end

        // stage payload
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lo_reg[s]   <= lo_next[s];
                side_reg[s] <= side_prev;
            end
        end

        // remainder and divisor only needed by later steps
        if (s < Q)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next[s];
                    den_reg[s] <= den_prev;
                end
            end
        end
    end

    assign out_vld  = vld_reg[Q];
    assign quo      = lo_reg[Q];
    assign side_out = side_reg[Q];

endmodule
